// File: rtl/tclux_pkg.sv
// Shared constants, types and the segment lookup of the two-channel lux calculator.
package tclux_pkg;

    // Fixed-point formats
    localparam int unsigned NOMINAL_CYCLES = 148;
    localparam int unsigned SCALE_BITS     = 16;
    localparam int unsigned RATIO_BITS     = 9;
    localparam int unsigned GAIN128_BROAD  = 107;
    localparam int unsigned GAIN128_IR     = 115;
    localparam int unsigned GAIN8_SHIFT    = 3;
    localparam int unsigned GAIN16_SHIFT   = 4;

    // Widths
    localparam int unsigned COUNT_W     = 16;
    localparam int unsigned SCALE_W     = 24;
    localparam int unsigned CHAN_W      = 24;
    localparam int unsigned QUO_W       = RATIO_BITS + 1;
    localparam int unsigned CYC_W       = 8;
    localparam int unsigned GAIN_W      = 2;
    localparam int unsigned CFG_DATA_W  = 8;
    localparam int unsigned CFG_INDEX_W = 1;
    localparam int unsigned INTERCEPT_W = 14;
    localparam int unsigned SLOPE_W     = 15;
    localparam int unsigned POS_W       = CHAN_W + INTERCEPT_W;
    localparam int unsigned NEG_W       = CHAN_W + SLOPE_W;
    localparam int unsigned DIFF_W      = NEG_W + 1;
    localparam int unsigned LUX_W       = 21;

    // Breakpoints (ratio, 9 fractional bits) and coefficients (16 fractional bits)
    localparam int unsigned KNEE0 = 'h009A;
    localparam int unsigned KNEE1 = 'h00c3;
    localparam int unsigned KNEE2 = 'h00e6;
    localparam int unsigned KNEE3 = 'h0114;
    localparam int unsigned ICPT0 = 'h2148;
    localparam int unsigned ICPT1 = 'h2a37;
    localparam int unsigned ICPT2 = 'h18ef;
    localparam int unsigned ICPT3 = 'h0fdf;
    localparam int unsigned SLOPE0 = 'h3d71;
    localparam int unsigned SLOPE1 = 'h5b30;
    localparam int unsigned SLOPE2 = 'h2db9;
    localparam int unsigned SLOPE3 = 'h199a;

    // Register indexes of the configuration port
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_GAIN_MODE   = 1'b0,
        REG_INTEGRATION = 1'b1
    } cfg_reg_t;

    typedef enum logic [GAIN_W-1:0] {
        GAIN_1X   = 2'd0,
        GAIN_8X   = 2'd1,
        GAIN_16X  = 2'd2,
        GAIN_128X = 2'd3
    } gain_t;

    // Per-channel scale, 16 fractional bits
    typedef struct packed {
        logic [SCALE_W-1:0] broad;
        logic [SCALE_W-1:0] ir;
    } scale_t;

    // Payload carried through the ratio divider
    typedef struct packed {
        logic [CHAN_W-1:0] c0;
        logic [CHAN_W-1:0] c1;
        logic [CHAN_W-1:0] rem;
        logic [QUO_W-1:0]  quo;
        logic              zero;   // scaled broadband is zero
        logic              over;   // ratio at or above one
    } div_t;

    typedef struct packed {
        logic [INTERCEPT_W-1:0] b;
        logic [SLOPE_W-1:0]     m;
    } coef_t;

    // quo = floor(c1 * 2^10 / c0); rounded ratio <= knee  <=>  quo <= 2 * knee
    function automatic coef_t seg_select(input logic [QUO_W-1:0] quo,
                                         input logic zero, input logic over);
        coef_t c;
        c = '0;
        if (zero || (!over && quo <= QUO_W'(2 * KNEE0))) begin
            c.b = INTERCEPT_W'(ICPT0);
            c.m = SLOPE_W'(SLOPE0);
        end
        else if (!over && quo <= QUO_W'(2 * KNEE1)) begin
            c.b = INTERCEPT_W'(ICPT1);
            c.m = SLOPE_W'(SLOPE1);
        end
        else if (!over && quo <= QUO_W'(2 * KNEE2)) begin
            c.b = INTERCEPT_W'(ICPT2);
            c.m = SLOPE_W'(SLOPE2);
        end
        else if (!over && quo <= QUO_W'(2 * KNEE3)) begin
            c.b = INTERCEPT_W'(ICPT3);
            c.m = SLOPE_W'(SLOPE3);
        end
        return c;
    endfunction

endpackage

// File: rtl/tclux_ifs.sv
// Valid/ready stream interfaces for the sample and result channels.
interface tclux_in_if;
    import tclux_pkg::*;
    logic               valid;
    logic               ready;
    logic [COUNT_W-1:0] broadband_count;
    logic [COUNT_W-1:0] infrared_count;

    modport source (output valid, output broadband_count, output infrared_count, input ready);
    modport sink   (input valid, input broadband_count, input infrared_count, output ready);
endinterface

interface tclux_out_if;
    import tclux_pkg::*;
    logic             valid;
    logic             ready;
    logic [LUX_W-1:0] lux;

    modport source (output valid, output lux, input ready);
    modport sink   (input valid, input lux, output ready);
endinterface

// File: rtl/tclux_cfg.sv
// Configuration registers and per-channel scale lookup.
module tclux_cfg (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [tclux_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [tclux_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    output tclux_pkg::scale_t                scale
);
    import tclux_pkg::*;

    localparam int unsigned CYC_N = 2 ** CYC_W;

    gain_t              gain_reg, gain_next;
    logic [CYC_W-1:0]   cycles_reg, cycles_next;
    scale_t             scale_reg, scale_next;
    logic [SCALE_W-1:0] base_tab [CYC_N];
    logic [SCALE_W-1:0] b128_tab [CYC_N];
    logic [SCALE_W-1:0] i128_tab [CYC_N];

    // Constant scale tables: (148 << 16) / cycles, zero cycles read as one
    for (genvar g = 0; g < CYC_N; g++)
    begin : g_tab
        localparam int unsigned DIVISOR = (g == 0) ? 1 : g;
        localparam int unsigned BASE    = (NOMINAL_CYCLES << SCALE_BITS) / DIVISOR;
        localparam int unsigned B128    = BASE / GAIN128_BROAD;
        localparam int unsigned I128    = BASE / GAIN128_IR;
        assign base_tab[g] = SCALE_W'(BASE);
        assign b128_tab[g] = SCALE_W'(B128);
        assign i128_tab[g] = SCALE_W'(I128);
    end

    // Register writes
    always_comb
    begin
        gain_next   = gain_reg;
        cycles_next = cycles_reg;
        if (cfg_we && cfg_index == REG_GAIN_MODE)
            gain_next = gain_t'(cfg_wdata[GAIN_W-1:0]);
        if (cfg_we && cfg_index == REG_INTEGRATION)
            cycles_next = cfg_wdata[CYC_W-1:0];
    end

    // Scale follows the new register values in the same cycle
    always_comb
    begin
        case (gain_next)
            GAIN_1X:
            begin
                scale_next.broad = base_tab[cycles_next];
                scale_next.ir    = base_tab[cycles_next];
            end
            GAIN_8X:
            begin
                scale_next.broad = base_tab[cycles_next] >> GAIN8_SHIFT;
                scale_next.ir    = base_tab[cycles_next] >> GAIN8_SHIFT;
            end
            GAIN_16X:
            begin
                scale_next.broad = base_tab[cycles_next] >> GAIN16_SHIFT;
                scale_next.ir    = base_tab[cycles_next] >> GAIN16_SHIFT;
            end
            GAIN_128X:
            begin
                scale_next.broad = b128_tab[cycles_next];
                scale_next.ir    = i128_tab[cycles_next];
            end
            default:
            begin
                scale_next.broad = base_tab[cycles_next];
                scale_next.ir    = base_tab[cycles_next];
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg        <= GAIN_1X;
            cycles_reg      <= CYC_W'(NOMINAL_CYCLES);
            scale_reg.broad <= SCALE_W'(1 << SCALE_BITS);
            scale_reg.ir    <= SCALE_W'(1 << SCALE_BITS);
        end
        else
        begin
            gain_reg   <= gain_next;
            cycles_reg <= cycles_next;
            scale_reg  <= scale_next;
        end
    end

    assign scale = scale_reg;

    // Only the 128x mode gives the channels different scales
    a_scale_match: assert property (@(posedge clk) disable iff (!rst_n)
        gain_reg != GAIN_128X |-> scale_reg.broad == scale_reg.ir)
        else $error("channel scales differ outside 128x mode");

endmodule

// File: rtl/tclux_div_step.sv
// One restoring-division stage of the ratio divider: one quotient bit per stage.
module tclux_div_step (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  tclux_pkg::div_t   in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output tclux_pkg::div_t   out_data
);
    import tclux_pkg::*;

    logic                valid_reg;
    div_t                data_reg, data_next;
    logic [CHAN_W:0]     rem2;
    logic                fits;
    logic                load;

    // Stage takes a request when empty or when its content moves on
    assign load     = !valid_reg || out_ready;
    assign in_ready = load;

    // Shift in one dividend bit, subtract where the divisor fits
    always_comb
    begin
        rem2      = {in_data.rem, 1'b0};
        fits      = rem2 >= {1'b0, in_data.c0};
        data_next = in_data;
        if (fits)
            data_next.rem = CHAN_W'(rem2 - {1'b0, in_data.c0});
        else
            data_next.rem = rem2[CHAN_W-1:0];
        data_next.quo = {in_data.quo[QUO_W-2:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (load)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (load && in_valid)
            data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    // Partial remainder stays below the divisor on the normal path
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && !data_reg.zero && !data_reg.over |-> data_reg.rem < data_reg.c0)
        else $error("divider remainder not below divisor");

endmodule

// File: rtl/tclux_lux.sv
// Segment pick, the two coefficient products, then clamp and round to whole lux.
module tclux_lux (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  tclux_pkg::div_t              in_data,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [tclux_pkg::LUX_W-1:0]  lux
);
    import tclux_pkg::*;

    coef_t               coef;
    logic                prod_valid_reg;
    logic [POS_W-1:0]    pos_reg, pos_next;
    logic [NEG_W-1:0]    neg_reg, neg_next;
    logic                lux_valid_reg;
    logic [LUX_W-1:0]    lux_reg, lux_next;
    logic [DIFF_W-1:0]   sum;
    logic                load_prod, load_lux;

    assign load_lux  = !lux_valid_reg || out_ready;
    assign load_prod = !prod_valid_reg || load_lux;
    assign in_ready  = load_prod;

    // Products b*ch0 and m*ch1
    always_comb
    begin
        coef     = seg_select(in_data.quo, in_data.zero, in_data.over);
        pos_next = POS_W'(in_data.c0) * POS_W'(coef.b);
        neg_next = NEG_W'(in_data.c1) * NEG_W'(coef.m);
    end

    // Clamp negative to zero, round off the fractional bits
    always_comb
    begin
        sum = DIFF_W'(NEG_W'(pos_reg) - neg_reg) + DIFF_W'(1 << (SCALE_BITS - 1));
        if (NEG_W'(pos_reg) > neg_reg)
            lux_next = sum[SCALE_BITS +: LUX_W];
        else
            lux_next = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
            lux_valid_reg  <= 1'b0;
        end
        else
        begin
            if (load_prod)
                prod_valid_reg <= in_valid;
            if (load_lux)
                lux_valid_reg <= prod_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_prod && in_valid)
        begin
            pos_reg <= pos_next;
            neg_reg <= neg_next;
        end
        if (load_lux && prod_valid_reg)
            lux_reg <= lux_next;
    end

    assign out_valid = lux_valid_reg;
    assign lux       = lux_reg;

endmodule

// File: rtl/two_channel_lux_calculator_core.sv
// Top level of the two-channel lux calculator: scaling, ratio divider, lux stages.
//
// Channel  Dir  Payload                           Handshake
// sample   in   broadband_count, infrared_count   valid / ready
// result   out  lux                               valid / ready
// cfg      in   cfg_index, cfg_wdata              cfg_we, no back-pressure
//
// One request per cycle while no stage stalls; a result passes through
// channel scaling, ten ratio-divider stages of one quotient bit each, the
// coefficient products and the rounding stage. Most stages belong to the divider.
// Reset is asynchronous: it empties the pipeline, sets gain 1x and the nominal integration time.
// A stalled stage holds its request; bubbles close up behind it, and sample.ready
// drops only when every stage is full.
module two_channel_lux_calculator_core (
    input  logic                              clk,
    input  logic                              rst_n,
    tclux_in_if.sink                          sample,
    tclux_out_if.source                       result,
    input  logic                              cfg_we,
    input  logic [tclux_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [tclux_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
    import tclux_pkg::*;

    localparam int unsigned PROD_W = COUNT_W + SCALE_W;

    scale_t             scale;
    logic               s1_valid_reg;
    logic [CHAN_W-1:0]  c0_reg, c0_next;
    logic [CHAN_W-1:0]  c1_reg, c1_next;
    logic [PROD_W-1:0]  prod0, prod1;
    logic               load_s1;
    logic               div_valid [QUO_W+1];
    logic               div_ready [QUO_W+1];
    div_t               div_data  [QUO_W+1];

    tclux_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .scale     (scale)
    );

    // Stage 1: scale both channels to nominal integration and 1x gain
    assign load_s1      = !s1_valid_reg || div_ready[0];
    assign sample.ready = load_s1;

    always_comb
    begin
        prod0   = PROD_W'(sample.broadband_count) * PROD_W'(scale.broad);
        prod1   = PROD_W'(sample.infrared_count) * PROD_W'(scale.ir);
        c0_next = prod0[SCALE_BITS +: CHAN_W];
        c1_next = prod1[SCALE_BITS +: CHAN_W];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (load_s1)
            s1_valid_reg <= sample.valid;
    end

    always_ff @(posedge clk)
    begin
        if (load_s1 && sample.valid)
        begin
            c0_reg <= c0_next;
            c1_reg <= c1_next;
        end
    end

    // Divider entry: dividend c1 << 10 over c0, ratio of one or more is flagged
    assign div_valid[0]     = s1_valid_reg;
    assign div_data[0].c0   = c0_reg;
    assign div_data[0].c1   = c1_reg;
    assign div_data[0].rem  = c1_reg;
    assign div_data[0].quo  = '0;
    assign div_data[0].zero = c0_reg == '0;
    assign div_data[0].over = c1_reg >= c0_reg;

    // Ratio divider, one quotient bit per stage
    for (genvar k = 0; k < QUO_W; k++)
    begin : g_div
        tclux_div_step u_step (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (div_valid[k]),
            .in_ready  (div_ready[k]),
            .in_data   (div_data[k]),
            .out_valid (div_valid[k+1]),
            .out_ready (div_ready[k+1]),
            .out_data  (div_data[k+1])
        );
    end

    tclux_lux u_lux (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (div_valid[QUO_W]),
        .in_ready  (div_ready[QUO_W]),
        .in_data   (div_data[QUO_W]),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .lux       (result.lux)
    );

    // An empty first stage always takes a request
    a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_valid_reg |-> sample.ready)
        else $error("sample stalled with empty first stage");

endmodule
